>>> rtl/core/motor_feedback_angle_unwrap_top_defines.svh
// Assertion macros shared by the RTL of the angle unwrap block.
`ifndef MOTOR_FEEDBACK_ANGLE_UNWRAP_TOP_DEFINES_SVH
`define MOTOR_FEEDBACK_ANGLE_UNWRAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFAU_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MFAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MFAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFAU_ASSERT(lbl, expr, msg)
`define MFAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define MFAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/mfau_pkg.sv
package mfau_pkg;

    localparam int ID_W    = 11;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int TEMP_W  = 8;
    localparam int CUR_W   = ANGLE_W + 1;
    localparam int OUT_TOTAL_W = 32;

    localparam logic [ID_W-1:0] FEEDBACK_BASE_RESET = 11'h201;
    localparam int COUNTS_PER_TURN_DEFAULT = 8192;
    localparam int TOTAL_WIDTH_DEFAULT     = 32;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_ONE   = 0;
    localparam int SLOT_TWO   = 1;
    localparam int SLOT_THREE = 2;
    localparam int SLOT_FOUR  = 3;

    localparam int IN_ID_LSB    = 0;
    localparam int IN_ANGLE_LSB = IN_ID_LSB + ID_W;
    localparam int IN_SPEED_LSB = IN_ANGLE_LSB + ANGLE_W;
    localparam int IN_TEMP_LSB  = IN_SPEED_LSB + SPEED_W;
    localparam int IN_USED_W    = IN_TEMP_LSB + TEMP_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_TDATA_W = 4 * ANGLE_W + 4 * SPEED_W + 2 * TEMP_W
                                 + 2 * OUT_TOTAL_W;

endpackage

>>> rtl/core/motor_feedback_angle_unwrap_top.sv
// Channel     Direction  Beat contents
// s_axis      in         frame identifier, angle, speed and temperature of one frame
// m_axis      out        stored slot values and both multi-turn totals
// cfg         in         feedback base identifier
//
// One beat is taken per cycle unless a stall on m_tready holds the pipeline.
// The input register and the slot registers form a two-stage pipeline with the
// combinational unwrap between them.
// A stall on m_tready holds the slot registers and backs up into s_tready.
// Reset restores every slot, offset and total to zero and the base to 0x201.
module motor_feedback_angle_unwrap_top #(
    parameter int COUNTS_PER_TURN = mfau_pkg::COUNTS_PER_TURN_DEFAULT,
    parameter int TOTAL_WIDTH     = mfau_pkg::TOTAL_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frame_id, angle_raw, speed_raw, temp_raw, zero pad
    input  logic [mfau_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // motor_one_angle, motor_one_speed, motor_one_temp, motor_two_angle,
    // motor_two_speed, motor_two_temp, motor_three_angle, motor_three_speed,
    // motor_four_angle, motor_four_speed, total_three, total_four
    output logic [mfau_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfau_pkg::ID_W-1:0]         cfg_data
);
    import mfau_pkg::*;

`include "motor_feedback_angle_unwrap_top_defines.svh"

    localparam int TURN_W = $clog2(COUNTS_PER_TURN + 1);
    localparam int STEP_W = ((TURN_W > CUR_W) ? TURN_W : CUR_W) + 2;

    function automatic logic signed [STEP_W-1:0] pick_step(
        input logic signed [CUR_W-1:0] cur,
        input logic signed [CUR_W-1:0] prev
    );
        logic signed [STEP_W-1:0] plain;
        logic signed [STEP_W-1:0] adj;
        logic signed [STEP_W-1:0] turn;
        logic [STEP_W-1:0] mag_plain;
        logic [STEP_W-1:0] mag_adj;
        plain = STEP_W'(cur) - STEP_W'(prev);
        turn  = STEP_W'(COUNTS_PER_TURN);
        adj   = (prev > cur) ? plain + turn : plain - turn;
        mag_plain = plain[STEP_W-1] ? -plain : plain;
        mag_adj   = adj[STEP_W-1] ? -adj : adj;
        return (mag_adj > mag_plain) ? plain : adj;
    endfunction

    logic                         in_valid_reg;
    logic [IN_TDATA_W-1:0]        in_data_reg;
    logic                         out_valid_reg;
    logic [ID_W-1:0]              base_reg;

    logic signed [ANGLE_W-1:0]    one_angle_reg, two_angle_reg;
    logic signed [ANGLE_W-1:0]    three_angle_reg, four_angle_reg;
    logic signed [SPEED_W-1:0]    one_speed_reg, two_speed_reg;
    logic signed [SPEED_W-1:0]    three_speed_reg, four_speed_reg;
    logic [TEMP_W-1:0]            one_temp_reg, two_temp_reg;
    logic signed [ANGLE_W-1:0]    offset_three_reg, offset_four_reg;
    logic signed [CUR_W-1:0]      prev_three_reg, prev_four_reg;
    logic [TOTAL_WIDTH-1:0]       sum_three_reg, sum_four_reg;

    logic signed [ANGLE_W-1:0]    three_angle_next, four_angle_next;
    logic signed [ANGLE_W-1:0]    offset_three_next, offset_four_next;
    logic signed [CUR_W-1:0]      prev_three_next, prev_four_next;
    logic [TOTAL_WIDTH-1:0]       sum_three_next, sum_four_next;

    logic                         out_free;
    logic                         advance;
    logic [ID_W-1:0]              in_id;
    logic signed [ANGLE_W-1:0]    in_angle;
    logic signed [SPEED_W-1:0]    in_speed;
    logic [TEMP_W-1:0]            in_temp;
    logic [NUM_SLOTS-1:0]         hit;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

    assign in_id    = in_data_reg[IN_ANGLE_LSB-1:IN_ID_LSB];
    assign in_angle = in_data_reg[IN_SPEED_LSB-1:IN_ANGLE_LSB];
    assign in_speed = in_data_reg[IN_TEMP_LSB-1:IN_SPEED_LSB];
    assign in_temp  = in_data_reg[IN_USED_W-1:IN_TEMP_LSB];

    always_comb
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            hit[k] = ({1'b0, in_id} == ({1'b0, base_reg} + (ID_W + 1)'(k)));
        end
    end

    always_comb
    begin
        three_angle_next = hit[SLOT_THREE] ? in_angle : three_angle_reg;
        four_angle_next  = hit[SLOT_FOUR] ? in_angle : four_angle_reg;

        offset_three_next = (offset_three_reg == '0 && three_angle_next > 16'sd1)
                            ? three_angle_next : offset_three_reg;
        offset_four_next  = (offset_four_reg == '0 && four_angle_next > 16'sd1)
                            ? four_angle_next : offset_four_reg;

        prev_three_next = CUR_W'(three_angle_next) - CUR_W'(offset_three_next);
        prev_four_next  = CUR_W'(four_angle_next) - CUR_W'(offset_four_next);

        sum_three_next = sum_three_reg
                         + TOTAL_WIDTH'(pick_step(prev_three_next, prev_three_reg));
        sum_four_next  = sum_four_reg
                         + TOTAL_WIDTH'(pick_step(prev_four_next, prev_four_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= FEEDBACK_BASE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_angle_reg    <= '0;
            one_speed_reg    <= '0;
            one_temp_reg     <= '0;
            two_angle_reg    <= '0;
            two_speed_reg    <= '0;
            two_temp_reg     <= '0;
            three_angle_reg  <= '0;
            three_speed_reg  <= '0;
            four_angle_reg   <= '0;
            four_speed_reg   <= '0;
            offset_three_reg <= '0;
            offset_four_reg  <= '0;
            prev_three_reg   <= '0;
            prev_four_reg    <= '0;
            sum_three_reg    <= '0;
            sum_four_reg     <= '0;
        end
        else if (advance)
        begin
            if (hit[SLOT_ONE])
            begin
                one_angle_reg <= in_angle;
                one_speed_reg <= in_speed;
                one_temp_reg  <= in_temp;
            end
            if (hit[SLOT_TWO])
            begin
                two_angle_reg <= in_angle;
                two_speed_reg <= in_speed;
                two_temp_reg  <= in_temp;
            end
            if (hit[SLOT_THREE])
            begin
                three_speed_reg <= in_speed;
            end
            if (hit[SLOT_FOUR])
            begin
                four_speed_reg <= in_speed;
            end
            three_angle_reg  <= three_angle_next;
            four_angle_reg   <= four_angle_next;
            offset_three_reg <= offset_three_next;
            offset_four_reg  <= offset_four_next;
            prev_three_reg   <= prev_three_next;
            prev_four_reg    <= prev_four_next;
            sum_three_reg    <= sum_three_next;
            sum_four_reg     <= sum_four_next;
        end
    end

    assign m_tdata = {OUT_TOTAL_W'(sum_four_reg), OUT_TOTAL_W'(sum_three_reg),
                      four_speed_reg, four_angle_reg,
                      three_speed_reg, three_angle_reg,
                      two_temp_reg, two_speed_reg, two_angle_reg,
                      one_temp_reg, one_speed_reg, one_angle_reg};

    `MFAU_ASSERT_NEXT(a_offset_three_kept, offset_three_reg != '0, offset_three_reg != '0,
        "Latched offset of slot three was lost")
    `MFAU_ASSERT_IMPL(a_offset_four_above_one, offset_four_reg != '0,
        offset_four_reg > 16'sd1, "Latched offset of slot four is not above one")
    `MFAU_ASSERT_NEXT(a_totals_hold, !advance,
        $stable(sum_three_reg) && $stable(sum_four_reg), "Totals moved without a beat")
    `MFAU_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && !advance,
        in_valid_reg && $stable(in_data_reg), "Waiting input beat was dropped")

endmodule
